// File: hw/rtl/b3d_pkg.sv
`default_nettype none

package b3d_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned MAX_HEIGHT    = 4096;
  localparam int unsigned WIDTH_RST     = 1920;
  localparam int unsigned HEIGHT_RST    = 1080;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned PART_W  = 10;
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned CH_N    = 3;
  localparam int unsigned ENTRY_W = CH_N * SUM_W;
  localparam int unsigned CFG_DW  = 13;
  localparam int unsigned CFG_IW  = 2;
  localparam int unsigned WREG_W  = 12;
  localparam int unsigned HREG_W  = 13;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned BLK_W   = 11;

  typedef enum logic [CFG_IW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } reg_idx_e;

  localparam logic [1:0] PH0 = 2'd0;
  localparam logic [1:0] PH1 = 2'd1;
  localparam logic [1:0] PH2 = 2'd2;

  typedef struct packed {
    logic [1:0] cp;
    logic [1:0] rp;
    logic       kept;
    logic       blk_last;
    logic       byp_last;
    logic       bypass;
  } pos_t;

  function automatic logic [BLK_W-1:0] div3(input logic [HREG_W-1:0] x);
    logic [29:0] p;
    p = {17'b0, x} * 30'd43691;
    return p[17 +: BLK_W];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/b3d_sum_mem.sv
`default_nettype none

module b3d_sum_mem #(
  parameter int unsigned DEPTH = b3d_pkg::MAX_WIDTH_DEF / 3,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         re_i,
  input  wire logic [AW-1:0]                raddr_i,
  output      logic [b3d_pkg::ENTRY_W-1:0]  rdata_o,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                waddr_i,
  input  wire logic [b3d_pkg::ENTRY_W-1:0]  wdata_i
);

  logic [b3d_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/b3d_ctrl.sv
`default_nettype none

module b3d_ctrl #(
  parameter int unsigned MAX_WIDTH = b3d_pkg::MAX_WIDTH_DEF,
  localparam int unsigned SW = (((MAX_WIDTH - 1) / 3 + 1) > 1) ?
                               $clog2((MAX_WIDTH - 1) / 3 + 1) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  input  wire logic [b3d_pkg::CFG_IW-1:0]  cfg_index_i,
  input  wire logic [b3d_pkg::CFG_DW-1:0]  cfg_data_i,
  input  wire logic                        adv_i,
  output      b3d_pkg::pos_t               pos_o,
  output      logic [SW-1:0]               slot_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned CMPW  = 14;
  localparam int unsigned WSAT  = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
  localparam int unsigned W_RST = (b3d_pkg::WIDTH_RST > MAX_WIDTH) ?
                                  MAX_WIDTH : b3d_pkg::WIDTH_RST;

  logic [b3d_pkg::WREG_W-1:0] w_q, w_d;
  logic [b3d_pkg::BLK_W-1:0]  w3_q, w3_d;
  logic [b3d_pkg::HREG_W-1:0] h_q, h_d;
  logic [b3d_pkg::BLK_W-1:0]  h3_q, h3_d;
  logic                       mode_q, mode_d;

  logic [CW-1:0]             c_q, c_d;
  logic [b3d_pkg::ROW_W-1:0] r_q, r_d;
  logic [1:0]                cp_q, cp_d, rp_q, rp_d;
  logic [SW-1:0]             slot_q, slot_d;
  logic [b3d_pkg::BLK_W-1:0] rslot_q, rslot_d;

  logic [b3d_pkg::WREG_W-1:0] w_raw;
  logic [b3d_pkg::HREG_W-1:0] h_raw;
  logic [CMPW-1:0]            c_x, r_x, wm1_x, hm1_x;
  logic                       wrap_c, wrap_r, over_r;

  always_comb begin
    w_d    = w_q;
    w3_d   = w3_q;
    h_d    = h_q;
    h3_d   = h3_q;
    mode_d = mode_q;
    w_raw  = cfg_data_i[b3d_pkg::WREG_W-1:0];
    h_raw  = cfg_data_i[b3d_pkg::HREG_W-1:0];
    if (cfg_valid_i) begin
      case (cfg_index_i)
        b3d_pkg::REG_WIDTH: begin
          if (w_raw == '0) begin
            w_d = b3d_pkg::WREG_W'(1);
          end else if ({2'b0, w_raw} > CMPW'(WSAT)) begin
            w_d = b3d_pkg::WREG_W'(WSAT);
          end else begin
            w_d = w_raw;
          end
          w3_d = b3d_pkg::div3({1'b0, w_d});
        end
        b3d_pkg::REG_HEIGHT: begin
          if (h_raw == '0) begin
            h_d = b3d_pkg::HREG_W'(1);
          end else if (h_raw > b3d_pkg::HREG_W'(b3d_pkg::MAX_HEIGHT)) begin
            h_d = b3d_pkg::HREG_W'(b3d_pkg::MAX_HEIGHT);
          end else begin
            h_d = h_raw;
          end
          h3_d = b3d_pkg::div3(h_d);
        end
        b3d_pkg::REG_MODE: begin
          mode_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    c_x    = CMPW'(c_q);
    r_x    = CMPW'(r_q);
    wm1_x  = CMPW'(w_q) - CMPW'(1);
    hm1_x  = CMPW'(h_q) - CMPW'(1);
    wrap_c = c_x >= wm1_x;
    wrap_r = r_x >= hm1_x;
    over_r = r_x > hm1_x;

    c_d     = c_q;
    r_d     = r_q;
    cp_d    = cp_q;
    rp_d    = rp_q;
    slot_d  = slot_q;
    rslot_d = rslot_q;
    if (adv_i) begin
      if (wrap_c) begin
        c_d    = '0;
        cp_d   = b3d_pkg::PH0;
        slot_d = '0;
        if (wrap_r) begin
          r_d     = '0;
          rp_d    = b3d_pkg::PH0;
          rslot_d = '0;
        end else begin
          r_d = r_q + b3d_pkg::ROW_W'(1);
          if (rp_q == b3d_pkg::PH2) begin
            rp_d    = b3d_pkg::PH0;
            rslot_d = rslot_q + b3d_pkg::BLK_W'(1);
          end else begin
            rp_d = rp_q + 2'd1;
          end
        end
      end else begin
        c_d = c_q + CW'(1);
        if (cp_q == b3d_pkg::PH2) begin
          cp_d   = b3d_pkg::PH0;
          slot_d = slot_q + SW'(1);
        end else begin
          cp_d = cp_q + 2'd1;
        end
        if (over_r) begin
          r_d     = '0;
          rp_d    = b3d_pkg::PH0;
          rslot_d = '0;
        end
      end
    end
  end

  always_comb begin
    pos_o.cp       = cp_q;
    pos_o.rp       = rp_q;
    pos_o.kept     = (CMPW'(slot_q) < CMPW'(w3_q)) && (CMPW'(rslot_q) < CMPW'(h3_q));
    pos_o.blk_last = (CMPW'(slot_q) == CMPW'(w3_q) - CMPW'(1)) &&
                     (CMPW'(rslot_q) == CMPW'(h3_q) - CMPW'(1));
    pos_o.byp_last = wrap_c && wrap_r;
    pos_o.bypass   = !mode_q;
    slot_o         = slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= b3d_pkg::WREG_W'(W_RST);
      w3_q    <= b3d_pkg::BLK_W'(W_RST / 3);
      h_q     <= b3d_pkg::HREG_W'(b3d_pkg::HEIGHT_RST);
      h3_q    <= b3d_pkg::BLK_W'(b3d_pkg::HEIGHT_RST / 3);
      mode_q  <= 1'b1;
      c_q     <= '0;
      r_q     <= '0;
      cp_q    <= b3d_pkg::PH0;
      rp_q    <= b3d_pkg::PH0;
      slot_q  <= '0;
      rslot_q <= '0;
    end else begin
      w_q     <= w_d;
      w3_q    <= w3_d;
      h_q     <= h_d;
      h3_q    <= h3_d;
      mode_q  <= mode_d;
      c_q     <= c_d;
      r_q     <= r_d;
      cp_q    <= cp_d;
      rp_q    <= rp_d;
      slot_q  <= slot_d;
      rslot_q <= rslot_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/binomial_3x3_decimator_core.sv
`default_nettype none

// Binomial 3x3 decimator: takes one raster-order BGR pixel per clock while
// the input is not stalled and, in downsample mode, emits one 1-2-1 x 1-2-1
// weighted pixel (sum / 16) per non-overlapping 3x3 block, at the block's
// bottom-right pixel; leftover columns and rows are dropped. In bypass mode
// every pixel passes. The block sustains one request per clock unless the
// output stalls: the horizontal sum is kept in flops, and the per-column
// vertical sums live in a single-port-per-side memory read when a block's
// third column arrives and written back as that request leaves the first
// stage, which a request holds while its result waits on a stalled output.
// A result passes from the first stage into the output register. The input
// stalls only while a finished result sits in the first stage behind a
// stalled output register. The column-sum memory has no reset and needs no
// clearing pass; on the first row of a row triple the read value is unused
// and each entry is written. frame_end marks the last result of a frame.
module binomial_3x3_decimator_core #(
  parameter int unsigned MAX_WIDTH = b3d_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output      logic                        cfg_ready_o,
  input  wire logic [b3d_pkg::CFG_IW-1:0]  cfg_index_i,
  input  wire logic [b3d_pkg::CFG_DW-1:0]  cfg_data_i,
  input  wire logic                        in_valid_i,
  output      logic                        in_stall_o,
  input  wire logic [b3d_pkg::PIX_W-1:0]   blue_in_i,
  input  wire logic [b3d_pkg::PIX_W-1:0]   green_in_i,
  input  wire logic [b3d_pkg::PIX_W-1:0]   red_in_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_stall_i,
  output      logic [b3d_pkg::PIX_W-1:0]   blue_out_o,
  output      logic [b3d_pkg::PIX_W-1:0]   green_out_o,
  output      logic [b3d_pkg::PIX_W-1:0]   red_out_o,
  output      logic                        frame_end_o
);

  localparam int unsigned SW = (((MAX_WIDTH - 1) / 3 + 1) > 1) ?
                               $clog2((MAX_WIDTH - 1) / 3 + 1) : 1;
  localparam int unsigned SUM_DEPTH = MAX_WIDTH / 3;
  localparam int unsigned AW = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int unsigned PW = b3d_pkg::PART_W;
  localparam int unsigned QW = b3d_pkg::SUM_W;
  localparam int unsigned NC = b3d_pkg::CH_N;

  b3d_pkg::pos_t pos;
  logic [SW-1:0] slot;
  logic          in_acc;

  logic [b3d_pkg::PIX_W-1:0] pix [NC];
  logic [PW-1:0]             part_q [NC];
  logic [PW-1:0]             part_d [NC];
  logic [PW-1:0]             term   [NC];
  logic                      part_we;

  logic                 s1_valid_q, s1_valid_d;
  logic                 s1_byp_q, s1_emit_q, s1_last_q;
  logic [1:0]           s1_rp_q;
  logic [AW-1:0]        s1_slot_q;
  logic [PW-1:0]        s1_val_q [NC];
  logic                 s1_load, s1_adv, s1_ready;

  logic [b3d_pkg::ENTRY_W-1:0] mem_rdata, mem_wdata;
  logic                        mem_re, mem_we;
  logic [QW-1:0]               vsum [NC];
  logic [QW-1:0]               vterm [NC];

  logic                      out_valid_q, out_valid_d;
  logic                      out_free, out_load;
  logic [b3d_pkg::PIX_W-1:0] out_q [NC];
  logic                      out_last_q;

  assign cfg_ready_o = 1'b1;

  b3d_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .adv_i       (in_acc),
    .pos_o       (pos),
    .slot_o      (slot)
  );

  assign pix[0] = blue_in_i;
  assign pix[1] = green_in_i;
  assign pix[2] = red_in_i;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!s1_emit_q || out_free);
  assign s1_ready   = !s1_valid_q || s1_adv;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      term[k] = (pos.cp == b3d_pkg::PH1) ? PW'({pix[k], 1'b0}) : PW'(pix[k]);
      part_d[k] = (pos.cp == b3d_pkg::PH0) ? term[k] : part_q[k] + term[k];
    end
  end

  assign part_we = in_acc && !pos.bypass && pos.kept;
  assign s1_load = in_acc && (pos.bypass || (pos.kept && pos.cp == b3d_pkg::PH2));
  assign mem_re  = s1_load && !pos.bypass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NC; k++) begin
        part_q[k] <= '0;
      end
    end else if (part_we) begin
      part_q <= part_d;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_byp_q  <= pos.bypass;
      s1_emit_q <= pos.bypass || (pos.rp == b3d_pkg::PH2);
      s1_last_q <= pos.bypass ? pos.byp_last : (pos.blk_last && pos.rp == b3d_pkg::PH2);
      s1_rp_q   <= pos.rp;
      s1_slot_q <= slot[AW-1:0];
      for (int k = 0; k < NC; k++) begin
        s1_val_q[k] <= pos.bypass ? PW'(pix[k]) : part_d[k];
      end
    end
  end

  b3d_sum_mem #(
    .DEPTH (SUM_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (slot[AW-1:0]),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (s1_slot_q),
    .wdata_i (mem_wdata)
  );

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      vterm[k] = (s1_rp_q == b3d_pkg::PH1) ? QW'({s1_val_q[k], 1'b0}) : QW'(s1_val_q[k]);
      vsum[k]  = (s1_rp_q == b3d_pkg::PH0) ? vterm[k] :
                 mem_rdata[k*QW +: QW] + vterm[k];
      mem_wdata[k*QW +: QW] = vsum[k];
    end
  end

  assign mem_we = s1_adv && !s1_byp_q;

  assign out_load = s1_valid_q && s1_emit_q && out_free;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = out_load;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_last_q <= s1_last_q;
      for (int k = 0; k < NC; k++) begin
        out_q[k] <= s1_byp_q ? s1_val_q[k][b3d_pkg::PIX_W-1:0] : vsum[k][QW-1 -: b3d_pkg::PIX_W];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign blue_out_o  = out_q[0];
  assign green_out_o = out_q[1];
  assign red_out_o   = out_q[2];
  assign frame_end_o = out_last_q;

  a_no_rw_collide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (s1_slot_q != slot[AW-1:0]))
    else $error("column sum read and write hit the same entry");

  a_stall_needs_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_emit_q && out_valid_q))
    else $error("input stalled without a pending result");

  a_s1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_slot_q)))
    else $error("blocked stage lost its request");

endmodule

`default_nettype wire
